// ===== hw/rtl/slpd_pkg.sv =====
// ----------------------------------------------------------------------------
// slpd_pkg: shared types and constants for the packet deframer
// Framing bytes, store positions, the packet descriptor handed from the parser
// to the drain side, and the drain state encoding.
// ----------------------------------------------------------------------------
package slpd_pkg;

    localparam int unsigned STORE_BYTES_DEF = 52;

    localparam logic [7:0] SYNC_FIRST  = 8'hFF;
    localparam logic [7:0] SYNC_SECOND = 8'h2D;

    // Store positions: length byte, first header byte, first payload byte.
    localparam int unsigned LEN_POS       = 2;
    localparam int unsigned HEADER_START  = 3;
    localparam int unsigned PAYLOAD_START = 7;
    localparam int unsigned HDR_BYTES     = 4;

    // Header bytes in order: command index, action, device, port.
    typedef logic [HDR_BYTES-1:0][7:0] t_hdr;

    typedef struct packed {
        t_hdr hdr;
        logic bank;
        logic has_payload;
    } t_pkt_desc;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_SEND
    } t_back_state;

endpackage

// ===== hw/rtl/sync_length_packet_deframer.sv =====
// Result path: a packet's final byte's transfer registers its descriptor in the queue; the
//   idle drain side then reads the first payload byte (skipped without payload) and sends.
// Throughput in: one byte per cycle while a payload buffer bank is free; input
//   stalls only when both banks hold packets that have not yet drained.
// Output: each packet starts from the idle state; each payload result then takes a buffer
//   read and a send that waits for tready; a packet without payload goes idle to send.
// Reset: synchronous, active low; clears parser state, header bytes and the queue.
//   The payload buffer is not cleared.
// ----------------------------------------------------------------------------
// sync_length_packet_deframer: sync-and-length framed packet deframer
// Bytes arrive one per transfer. The parser waits for the sync pair 0xFF, 0x2D,
// takes a length byte L and then L data bytes. Positions 3 to 6 are header
// bytes (command index, action, device, port) kept in registers; positions 7
// and up are payload and go into a two-bank buffer. A packet whose bytes reach
// the last store position is dropped without any result.
// A completed packet posts a descriptor into a two-entry queue. The drain side
// then sends one result per payload byte, each carrying the header, with tlast
// on the final one; a packet without payload gives a single result with tuser
// low. The parser keeps taking bytes of the next packet into the other bank
// while the previous one drains.
// ----------------------------------------------------------------------------
module sync_length_packet_deframer
    import slpd_pkg::*;
#(
    parameter int unsigned STORE_BYTES = STORE_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] rx_byte
    // Output stream.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // [7:0] cmd_seq, [15:8] action,
                                     // [23:16] device, [31:24] port,
                                     // [39:32] payload_byte
    output logic        o_m_tuser,   // [0] payload_valid
    output logic        o_m_tlast    // last result of the packet
);

    localparam int unsigned PW = $clog2(STORE_BYTES);

    logic          s_accept;
    logic          push;
    t_pkt_desc     push_desc;
    logic [PW-1:0] push_last_pos;
    logic          wr_en;
    logic [PW:0]   wr_addr;
    logic [7:0]    wr_data;
    logic          q_full;
    logic          q_empty;
    t_pkt_desc     head_desc;
    logic [PW-1:0] head_last_pos;
    logic          pop;

    // Each queue entry owns one buffer bank, so a full queue means the bank the
    // parser would write next is still being drained.
    assign o_s_tready = !q_full;
    assign s_accept   = i_s_tvalid && o_s_tready;

    slpd_front #(
        .STORE_BYTES(STORE_BYTES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (s_accept),
        .i_byte     (i_s_tdata),
        .o_push     (push),
        .o_desc     (push_desc),
        .o_last_pos (push_last_pos),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_wr_data  (wr_data)
    );

    slpd_queue #(
        .STORE_BYTES(STORE_BYTES)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_desc     (push_desc),
        .i_last_pos (push_last_pos),
        .i_pop      (pop),
        .o_full     (q_full),
        .o_empty    (q_empty),
        .o_desc     (head_desc),
        .o_last_pos (head_last_pos)
    );

    slpd_back #(
        .STORE_BYTES(STORE_BYTES)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (wr_en),
        .i_wr_addr  (wr_addr),
        .i_wr_data  (wr_data),
        .i_empty    (q_empty),
        .i_desc     (head_desc),
        .i_last_pos (head_last_pos),
        .o_pop      (pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

// ===== hw/rtl/slpd_front.sv =====
// ----------------------------------------------------------------------------
// slpd_front: byte parser
// Hunts for the sync pair, tracks the length count and store position, keeps
// the header bytes, writes payload bytes to the buffer and posts a descriptor
// for each completed packet.
// ----------------------------------------------------------------------------
module slpd_front
    import slpd_pkg::*;
#(
    parameter int unsigned STORE_BYTES = STORE_BYTES_DEF,
    localparam int unsigned PW = $clog2(STORE_BYTES)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic [7:0]    i_byte,
    output logic          o_push,
    output t_pkt_desc     o_desc,
    output logic [PW-1:0] o_last_pos,
    output logic          o_wr_en,
    output logic [PW:0]   o_wr_addr,
    output logic [7:0]    o_wr_data
);

    logic [7:0]    r_prev, n_prev;
    logic          r_in_pkt, n_in_pkt;
    logic [PW-1:0] r_pos, n_pos;
    logic [7:0]    r_remain, n_remain;
    t_hdr          r_hdr, n_hdr;
    logic          r_bank, n_bank;

    logic [PW-1:0] pos_cur;
    logic [PW:0]   pos_inc;
    logic          in_cur;
    logic [7:0]    remain;
    logic [1:0]    hdr_idx;
    logic          is_hdr_pos;
    logic          is_pay_pos;

    assign hdr_idx    = 2'(r_pos - PW'(HEADER_START));
    assign is_hdr_pos = (r_pos >= PW'(HEADER_START)) && (r_pos < PW'(PAYLOAD_START));
    assign is_pay_pos = (r_pos >= PW'(PAYLOAD_START));

    always_comb begin
        n_prev   = r_prev;
        n_in_pkt = r_in_pkt;
        n_pos    = r_pos;
        n_remain = r_remain;
        n_hdr    = r_hdr;
        n_bank   = r_bank;
        pos_cur  = r_pos;
        in_cur   = r_in_pkt;
        remain   = r_remain;
        pos_inc  = '0;
        o_push   = 1'b0;
        o_wr_en  = 1'b0;
        if (i_accept) begin
            if (i_byte == SYNC_SECOND && !r_in_pkt) begin
                // A lone second sync byte leaves the previous byte untouched.
                if (r_prev == SYNC_FIRST) begin
                    in_cur  = 1'b1;
                    pos_cur = PW'(1);
                end
            end else begin
                n_prev = i_byte;
                if (r_in_pkt) begin
                    if (r_pos == PW'(LEN_POS)) begin
                        remain = i_byte;
                    end else begin
                        remain = r_remain - 8'd1;
                    end
                    if (is_hdr_pos) begin
                        n_hdr[hdr_idx] = i_byte;
                    end
                    o_wr_en = is_pay_pos;
                end
            end
            n_remain = remain;
            pos_inc  = {1'b0, pos_cur} + (PW+1)'(1);
            if (pos_inc >= (PW+1)'(STORE_BYTES)) begin
                // Ran off the end of the store: drop the packet silently.
                in_cur = 1'b0;
                n_pos  = '0;
            end else begin
                n_pos = pos_inc[PW-1:0];
            end
            if (in_cur && remain == 8'd0 && pos_inc > (PW+1)'(HEADER_START)) begin
                in_cur = 1'b0;
                n_pos  = '0;
                o_push = 1'b1;
                n_bank = !r_bank;
            end
            n_in_pkt = in_cur;
        end
    end

    assign o_desc.hdr         = n_hdr;
    assign o_desc.bank        = r_bank;
    assign o_desc.has_payload = is_pay_pos;
    assign o_last_pos         = r_pos;
    assign o_wr_addr          = {r_bank, r_pos};
    assign o_wr_data          = i_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev   <= '0;
            r_in_pkt <= 1'b0;
            r_pos    <= '0;
            r_remain <= '0;
            r_hdr    <= '0;
            r_bank   <= 1'b0;
        end else begin
            r_prev   <= n_prev;
            r_in_pkt <= n_in_pkt;
            r_pos    <= n_pos;
            r_remain <= n_remain;
            r_hdr    <= n_hdr;
            r_bank   <= n_bank;
        end
    end

endmodule

// ===== hw/rtl/slpd_queue.sv =====
// ----------------------------------------------------------------------------
// slpd_queue: two-entry descriptor queue
// Holds completed packets between the parser and the drain side, one entry
// per payload buffer bank.
// ----------------------------------------------------------------------------
module slpd_queue
    import slpd_pkg::*;
#(
    parameter int unsigned STORE_BYTES = STORE_BYTES_DEF,
    localparam int unsigned PW = $clog2(STORE_BYTES)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  t_pkt_desc     i_desc,
    input  logic [PW-1:0] i_last_pos,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_empty,
    output t_pkt_desc     o_desc,
    output logic [PW-1:0] o_last_pos
);

    t_pkt_desc     r_desc [2];
    logic [PW-1:0] r_lpos [2];
    logic          r_wr_ptr;
    logic          r_rd_ptr;
    logic [1:0]    r_count;

    assign o_full     = (r_count == 2'd2);
    assign o_empty    = (r_count == 2'd0);
    assign o_desc     = r_desc[r_rd_ptr];
    assign o_last_pos = r_lpos[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_desc[r_wr_ptr] <= i_desc;
            r_lpos[r_wr_ptr] <= i_last_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

// ===== hw/rtl/slpd_back.sv =====
// ----------------------------------------------------------------------------
// slpd_back: payload buffer and result sequencer
// Owns the two-bank payload buffer and walks each queued packet, reading one
// payload byte per result and presenting it with the packet header.
// ----------------------------------------------------------------------------
module slpd_back
    import slpd_pkg::*;
#(
    parameter int unsigned STORE_BYTES = STORE_BYTES_DEF,
    localparam int unsigned PW = $clog2(STORE_BYTES),
    localparam int unsigned MEM_DEPTH = 2 * (1 << PW)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr_en,
    input  logic [PW:0]   i_wr_addr,
    input  logic [7:0]    i_wr_data,
    input  logic          i_empty,
    input  t_pkt_desc     i_desc,
    input  logic [PW-1:0] i_last_pos,
    output logic          o_pop,
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    output logic [39:0]   o_m_tdata,
    output logic          o_m_tuser,
    output logic          o_m_tlast
);

    logic [7:0]    mem [MEM_DEPTH];
    logic [7:0]    r_rd_data;
    t_back_state   r_state, n_state;
    logic [PW-1:0] r_pos, n_pos;
    logic          rd_en;
    logic          is_last;
    logic [7:0]    pay_byte;

    assign is_last  = !i_desc.has_payload || (r_pos == i_last_pos);
    assign pay_byte = i_desc.has_payload ? r_rd_data : 8'd0;

    always_comb begin
        n_state = r_state;
        n_pos   = r_pos;
        case (r_state)
            BK_IDLE: begin
                if (!i_empty) begin
                    n_pos   = PW'(PAYLOAD_START);
                    n_state = i_desc.has_payload ? BK_READ : BK_SEND;
                end
            end
            BK_READ: begin
                n_state = BK_SEND;
            end
            BK_SEND: begin
                if (i_m_tready) begin
                    if (is_last) begin
                        n_state = BK_IDLE;
                    end else begin
                        n_pos   = r_pos + PW'(1);
                        n_state = BK_READ;
                    end
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_comb begin
        rd_en      = (r_state == BK_READ);
        o_m_tvalid = (r_state == BK_SEND);
        o_pop      = (r_state == BK_SEND) && i_m_tready && is_last;
        o_m_tdata  = {pay_byte, i_desc.hdr};
        o_m_tuser  = i_desc.has_payload;
        o_m_tlast  = is_last;
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (rd_en) begin
            r_rd_data <= mem[{i_desc.bank, r_pos}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
            r_pos   <= '0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
        end
    end

endmodule
